>>> hw/rtl/cascaded_x2_interpolator_unit_assert.svh
// Assertion macros for the cascaded x2 interpolator.
// Included by the top level; depends on nothing else.
`ifndef CASCADED_X2_INTERPOLATOR_UNIT_ASSERT_SVH
`define CASCADED_X2_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define CX2I_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cx2i assertion failed");
// Next-cycle implication, checked out of reset.
`define CX2I_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cx2i assertion failed");
`else
`define CX2I_ASSERT_IMP(label, ante, cons)
`define CX2I_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/cx2i_pkg.sv
// Shared types, constants and arithmetic helpers for the cascaded x2 interpolator.
// Used by cx2i_cell and the top level; depends on nothing.
`timescale 1ns / 1ps
package cx2i_pkg;

  localparam int TAPS_STAGE_ONE   = 32;
  localparam int TAPS_STAGE_TWO   = 16;
  localparam int TAPS_STAGE_THREE = 12;
  localparam int TAPS_STAGE_FOUR  = 8;

  localparam int NUM_STAGES = 4;
  localparam int MAX_TAPS   = 64;
  localparam int HIST_MAX   = 32;
  localparam int ACC_W      = 40;

  // One complex word travelling along the chain.
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } smp_t;

  // One coefficient write towards a cell.
  typedef struct packed {
    logic               en;
    logic [5:0]         addr;
    logic signed [15:0] val;
  } coef_wr_t;

  // Clamped tap count of a stage (2 to 64).
  function automatic logic [6:0] clamp_taps(int n);
    int c;
    c = n;
    if (c < 2) c = 2;
    if (c > MAX_TAPS) c = MAX_TAPS;
    return 7'(c);
  endfunction

  function automatic logic [6:0] taps_of(logic [1:0] stage);
    logic [6:0] t;
    case (stage)
      2'd0:    t = clamp_taps(TAPS_STAGE_ONE);
      2'd1:    t = clamp_taps(TAPS_STAGE_TWO);
      2'd2:    t = clamp_taps(TAPS_STAGE_THREE);
      2'd3:    t = clamp_taps(TAPS_STAGE_FOUR);
      default: t = clamp_taps(TAPS_STAGE_ONE);
    endcase
    return t;
  endfunction

  // Round half up from Q10.30 sum to Q1.15 (including the gain of two), then saturate.
  function automatic logic signed [15:0] round_sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-15:0] q;
    logic signed [15:0] r;
    v = a + ACC_W'(8192);
    q = v[ACC_W-1:14];
    if (q > $signed((ACC_W-14)'(32767))) r = 16'sh7fff;
    else if (q < -$signed((ACC_W-14)'(32768))) r = 16'sh8000;
    else r = q[15:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/cx2i_cell.sv
// One x2 interpolation cell: delay line, coefficient memory and a shared complex MAC.
// Depends on cx2i_pkg.
`timescale 1ns / 1ps
module cx2i_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         stage_id_i,
  input  cx2i_pkg::coef_wr_t coef_wr_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cx2i_pkg::smp_t     in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cx2i_pkg::smp_t     out_word_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_OUT0  = 3'd3;
  localparam logic [2:0] ST_OUT1  = 3'd4;

  logic [6:0] taps;
  logic [5:0] hist_n;
  logic [4:0] hist_last;
  logic       off;

  logic signed [15:0] coef_mem [cx2i_pkg::MAX_TAPS];
  logic [cx2i_pkg::MAX_TAPS-1:0] coef_vld_q;
  logic signed [15:0] hist_re_q [cx2i_pkg::HIST_MAX];
  logic signed [15:0] hist_im_q [cx2i_pkg::HIST_MAX];

  logic [2:0] state_q, state_d;
  logic [4:0] m_q, m_d;
  logic       ph_q, ph_d;
  logic       in_last_q;
  logic [6:0] jj;
  logic       j_ok;

  logic               a_vld_q, a_first_q, a_last_q, a_ph_q, a_ok_q;
  logic signed [15:0] a_re_q, a_im_q, coef_rd_q;
  logic               p_vld_q, p_first_q, p_last_q, p_ph_q;
  logic signed [31:0] p_re_q, p_im_q;
  logic signed [cx2i_pkg::ACC_W-1:0] acc_re_q, acc_im_q, base_re, base_im;
  logic               fin_q, fin_ph_q;
  logic signed [15:0] res_re_q [2];
  logic signed [15:0] res_im_q [2];

  // Stage geometry from the stage index.
  assign taps      = cx2i_pkg::taps_of(stage_id_i);
  assign hist_n    = 6'((taps + 7'd1) >> 1);
  assign hist_last = 5'(hist_n - 6'd1);
  assign off       = taps[0];

  // Tap index of the current step; a wrapped negative index falls out of range.
  assign jj   = {1'b0, m_q, 1'b0} + {6'd0, ph_q} - {6'd0, off};
  assign j_ok = (jj < taps);

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (coef_wr_i.en && ({1'b0, coef_wr_i.addr} < taps)) begin
      coef_mem[coef_wr_i.addr] <= coef_wr_i.val;
    end
    coef_rd_q <= coef_mem[jj[5:0]];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (coef_wr_i.en && ({1'b0, coef_wr_i.addr} < taps)) begin
      coef_vld_q[coef_wr_i.addr] <= 1'b1;
    end
  end

  // Delay line shifts once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cx2i_pkg::HIST_MAX; i++) begin
        hist_re_q[i] <= '0;
        hist_im_q[i] <= '0;
      end
    end else if (state_q == ST_IDLE && in_valid_i) begin
      hist_re_q[0] <= in_word_i.re;
      hist_im_q[0] <= in_word_i.im;
      for (int i = 1; i < cx2i_pkg::HIST_MAX; i++) begin
        hist_re_q[i] <= hist_re_q[i-1];
        hist_im_q[i] <= hist_im_q[i-1];
      end
    end
  end

  // Sequencer over phases and taps.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    ph_d    = ph_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          m_d     = '0;
          ph_d    = 1'b0;
        end
      end
      ST_RUN: begin
        if (m_q == hist_last) begin
          m_d = '0;
          if (ph_q) state_d = ST_DRAIN;
          else ph_d = 1'b1;
        end else begin
          m_d = m_q + 5'd1;
        end
      end
      ST_DRAIN: begin
        if (fin_q && fin_ph_q) state_d = ST_OUT0;
      end
      ST_OUT0: begin
        if (out_ready_i) state_d = ST_OUT1;
      end
      ST_OUT1: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_q       <= '0;
      ph_q      <= 1'b0;
      in_last_q <= 1'b0;
      a_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      ph_q    <= ph_d;
      if (state_q == ST_IDLE && in_valid_i) in_last_q <= in_word_i.last;
      a_vld_q <= (state_q == ST_RUN);
      p_vld_q <= a_vld_q;
      fin_q   <= p_vld_q && p_last_q;
    end
  end

  // Fetch step: delay-line word and step flags.
  always_ff @(posedge clk_i) begin
    a_first_q <= (m_q == 5'd0);
    a_last_q  <= (m_q == hist_last);
    a_ph_q    <= ph_q;
    a_ok_q    <= j_ok && coef_vld_q[jj[5:0]];
    a_re_q    <= hist_re_q[m_q];
    a_im_q    <= hist_im_q[m_q];
  end

  // Multiply step: skipped taps contribute zero.
  always_ff @(posedge clk_i) begin
    p_first_q <= a_first_q;
    p_last_q  <= a_last_q;
    p_ph_q    <= a_ph_q;
    p_re_q    <= a_ok_q ? a_re_q * coef_rd_q : 32'sd0;
    p_im_q    <= a_ok_q ? a_im_q * coef_rd_q : 32'sd0;
  end

  // Accumulate step, then round the finished sum in the cycle after it completes.
  assign base_re = p_first_q ? '0 : acc_re_q;
  assign base_im = p_first_q ? '0 : acc_im_q;

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      acc_re_q <= base_re + {{(cx2i_pkg::ACC_W-32){p_re_q[31]}}, p_re_q};
      acc_im_q <= base_im + {{(cx2i_pkg::ACC_W-32){p_im_q[31]}}, p_im_q};
      fin_ph_q <= p_ph_q;
    end
    if (fin_q) begin
      res_re_q[fin_ph_q] <= cx2i_pkg::round_sat(acc_re_q);
      res_im_q[fin_ph_q] <= cx2i_pkg::round_sat(acc_im_q);
    end
  end

  // Even word first, then odd word carrying the run flag.
  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign out_word_o.re   = (state_q == ST_OUT1) ? res_re_q[1] : res_re_q[0];
  assign out_word_o.im   = (state_q == ST_OUT1) ? res_im_q[1] : res_im_q[0];
  assign out_word_o.last = (state_q == ST_OUT1) && in_last_q;

endmodule

>>> hw/rtl/cascaded_x2_interpolator_unit.sv
// Top level of the cascaded x2 interpolator: four cells in a row and an output register.
// Depends on cx2i_pkg, cx2i_cell and cascaded_x2_interpolator_unit_assert.svh.
`timescale 1ns / 1ps
`include "cascaded_x2_interpolator_unit_assert.svh"
// Complex Q1.15 samples (tuser = 0) pass through 1 to 4 interpolation cells, set by the
// stages register (0 acts as 1, above 4 as 4); each sample gives 2^stages words, the
// last flagged by tlast. Words with tuser = 1 load one coefficient and are taken only
// when the whole chain is empty. Each cell runs one complex multiply-accumulate per
// cycle; for each word it receives it takes the word, runs one step per tap pair in
// each of the two phases, drains its multiply-accumulate pipe and hands on its even
// and odd words. A cell takes no new word until the next cell has taken both of its
// words. The four cells have 32/16/12/8 taps, and receiver stalls hold up the chain.
module cascaded_x2_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_re [15:0], sample_im [31:16], coef_stage [33:32], coef_index [39:34],
  // coef_value [55:40]
  input  logic [55:0] s_axis_tdata,
  // mode [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_re [15:0], out_im [31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  logic [2:0] stages_q;
  logic [1:0] last_cell;

  logic [cx2i_pkg::NUM_STAGES-1:0] cin_valid, cin_ready, cout_valid, cout_ready;
  cx2i_pkg::smp_t   cin_word  [cx2i_pkg::NUM_STAGES];
  cx2i_pkg::smp_t   cout_word [cx2i_pkg::NUM_STAGES];
  cx2i_pkg::coef_wr_t cwr     [cx2i_pkg::NUM_STAGES];

  logic           out_vld_q;
  cx2i_pkg::smp_t out_word_q;
  logic           out_take;
  logic           all_idle;
  logic           in_acc;

  // Stage count register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= 3'd4;
    end else if (cfg_valid_i) begin
      stages_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (stages_q == 3'd0) last_cell = 2'd0;
    else if (stages_q > 3'd4) last_cell = 2'd3;
    else last_cell = 2'(stages_q - 3'd1);
  end

  // Input side: samples go to the first cell, loads wait for an empty chain.
  assign all_idle      = (&cin_ready) && !out_vld_q;
  assign s_axis_tready = s_axis_tuser ? all_idle : cin_ready[0];
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // The cell row.
  for (genvar k = 0; k < cx2i_pkg::NUM_STAGES; k++) begin : g_cell
    assign cwr[k].en   = in_acc && s_axis_tuser && (s_axis_tdata[33:32] == 2'(k));
    assign cwr[k].addr = s_axis_tdata[39:34];
    assign cwr[k].val  = s_axis_tdata[55:40];

    if (k == 0) begin : g_first
      assign cin_valid[k]     = s_axis_tvalid && !s_axis_tuser;
      assign cin_word[k].re   = s_axis_tdata[15:0];
      assign cin_word[k].im   = s_axis_tdata[31:16];
      assign cin_word[k].last = 1'b1;
    end else begin : g_next
      assign cin_valid[k] = cout_valid[k-1] && (2'(k - 1) < last_cell);
      assign cin_word[k]  = cout_word[k-1];
    end

    if (k == cx2i_pkg::NUM_STAGES - 1) begin : g_end
      assign cout_ready[k] = out_take;
    end else begin : g_mid
      assign cout_ready[k] = (2'(k) == last_cell) ? out_take : cin_ready[k+1];
    end

    cx2i_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_id_i  (2'(k)),
      .coef_wr_i   (cwr[k]),
      .in_valid_i  (cin_valid[k]),
      .in_ready_o  (cin_ready[k]),
      .in_word_i   (cin_word[k]),
      .out_valid_o (cout_valid[k]),
      .out_ready_i (cout_ready[k]),
      .out_word_o  (cout_word[k])
    );
  end

  // Output register fed by the last cell in use.
  assign out_take = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= cout_valid[last_cell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && cout_valid[last_cell]) begin
      out_word_q <= cout_word[last_cell];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_word_q.im, out_word_q.re};
  assign m_axis_tlast  = out_word_q.last;

  // A coefficient load never overlaps a sample in flight.
  `CX2I_ASSERT_NXT(a_load_leaves_idle, in_acc && s_axis_tuser, all_idle)
  // A sample entering the chain occupies the first cell next cycle.
  `CX2I_ASSERT_NXT(a_sample_busy, in_acc && !s_axis_tuser, !cin_ready[0])
  // Only the last cell in use feeds the output register.
  `CX2I_ASSERT_IMP(a_no_stray_out, cout_valid[3] && (last_cell != 2'd3), !cout_ready[3])

endmodule
